FILE: hw/rtl/link_keeper_with_backoff_top_macros.svh
// ----------------------------------------------------------------------------
// link keeper assertion macros
// shared concurrent assertion forms, reset-qualified, synchronous clock
// ----------------------------------------------------------------------------
`ifndef LINK_KEEPER_WITH_BACKOFF_TOP_MACROS_SVH
`define LINK_KEEPER_WITH_BACKOFF_TOP_MACROS_SVH

// same-cycle implication
`define LKB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lkb_pkg.sv
// ----------------------------------------------------------------------------
// lkb_pkg
// types, register map and reset values of the link keeper
// ----------------------------------------------------------------------------
package lkb_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned AddrW = 32;

  localparam logic [TimeW-1:0] StatusIntervalRst = 32'd5000;
  localparam logic [TimeW-1:0] RetryInitialRst   = 32'd1000;
  localparam logic [TimeW-1:0] RetryMaxRst       = 32'd60000;
  localparam logic [TimeW-1:0] SyncIntervalRst   = 32'd60000;

  typedef enum logic [1:0] {
    REG_STATUS_INTERVAL = 2'd0,
    REG_RETRY_INITIAL   = 2'd1,
    REG_RETRY_MAX       = 2'd2,
    REG_SYNC_INTERVAL   = 2'd3
  } lkb_reg_t;

  // tick as it arrives, highest field first
  typedef struct packed {
    logic [4:0]       pad;
    logic [AddrW-1:0] address_in;
    logic             sync_status;
    logic             connect_ok;
    logic             link_status;
    logic [TimeW-1:0] now_ms;
  } lkb_in_t;

  typedef struct packed {
    logic [TimeW-1:0] current_delay;
    logic [AddrW-1:0] local_address;
    logic             synced_flag;
    logic             link_up_flag;
    logic             address_changed_event;
    logic             synced_event;
    logic             disconnected_event;
    logic             connected_event;
    logic             sync_issued;
    logic             connect_issued;
  } lkb_out_t;

endpackage

FILE: hw/rtl/link_keeper_with_backoff_top.sv
// ----------------------------------------------------------------------------
// link_keeper_with_backoff_top
// link supervisor with exponential back-off connect retry and clock sync retry
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying the millisecond time and the
// platform answers; each tick yields exactly one result transaction with the
// issued commands, events, flags, stored address and retry delay. One tick is
// accepted per clock cycle while the result stream takes each result. The tick
// is captured in an input register, the state update is one pass of wrapping
// 32-bit compares, the delay doubling and selection, and the result is held in
// an output register, so one more tick is taken while a result waits. Registers
// must be written through the APB-style port only while the block is idle; the
// block itself does not enforce this. All registers sit at byte address 4*i.
// ----------------------------------------------------------------------------
module link_keeper_with_backoff_top
  import lkb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // tdata: now_ms[31:0], link_status[32], connect_ok[33], sync_status[34],
  //        address_in[66:35], zero pad[71:67]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  // tdata: connect_issued[0], sync_issued[1], connected_event[2],
  //        disconnected_event[3], synced_event[4], address_changed_event[5],
  //        link_up_flag[6], synced_flag[7], local_address[39:8],
  //        current_delay[71:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "link_keeper_with_backoff_top_macros.svh"

  logic [TimeW-1:0] status_interval_r, retry_initial_r, retry_max_r, sync_interval_r;
  logic             cfg_wr;
  lkb_reg_t         cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = lkb_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_interval_r <= StatusIntervalRst;
      retry_initial_r   <= RetryInitialRst;
      retry_max_r       <= RetryMaxRst;
      sync_interval_r   <= SyncIntervalRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_STATUS_INTERVAL: status_interval_r <= cfg_pwdata;
        REG_RETRY_INITIAL:   retry_initial_r   <= cfg_pwdata;
        REG_RETRY_MAX:       retry_max_r       <= cfg_pwdata;
        REG_SYNC_INTERVAL:   sync_interval_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_STATUS_INTERVAL: cfg_prdata = status_interval_r;
      REG_RETRY_INITIAL:   cfg_prdata = retry_initial_r;
      REG_RETRY_MAX:       cfg_prdata = retry_max_r;
      REG_SYNC_INTERVAL:   cfg_prdata = sync_interval_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic     in_valid_r, out_valid_r, advance;
  lkb_in_t  in_item_r;
  lkb_out_t out_item_r, out_item_nxt;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_item_r <= lkb_in_t'(in_tdata);
    if (advance) out_item_r <= out_item_nxt;
  end

  // link state
  logic             link_up_r, synced_r;
  logic [AddrW-1:0] addr_r;
  logic [TimeW-1:0] chk_time_r, att_time_r, delay_r, sync_time_r;

  logic             link_up_nxt, synced_nxt;
  logic [AddrW-1:0] addr_nxt;
  logic [TimeW-1:0] chk_time_nxt, att_time_nxt, delay_nxt, sync_time_nxt;
  logic [TimeW-1:0] now, grown_delay;
  logic             ev_connect, ev_sync, ev_up, ev_down, ev_synced, ev_addr;

  assign now = in_item_r.now_ms;

  always_comb begin
    if (delay_r == '0) grown_delay = retry_initial_r;
    else if (delay_r < (retry_max_r >> 1)) grown_delay = delay_r << 1;
    else grown_delay = retry_max_r;
  end

  always_comb begin
    link_up_nxt   = link_up_r;
    synced_nxt    = synced_r;
    addr_nxt      = addr_r;
    chk_time_nxt  = chk_time_r;
    att_time_nxt  = att_time_r;
    delay_nxt     = delay_r;
    sync_time_nxt = sync_time_r;
    ev_connect    = 1'b0;
    ev_sync       = 1'b0;
    ev_up         = 1'b0;
    ev_down       = 1'b0;
    ev_synced     = 1'b0;

    if (link_up_r) begin
      if (TimeW'(now - chk_time_r) >= status_interval_r) begin
        chk_time_nxt = now;
        if (in_item_r.link_status) begin
          addr_nxt = in_item_r.address_in;
        end else begin
          link_up_nxt = 1'b0;
          synced_nxt  = 1'b0;
          delay_nxt   = '0;
          addr_nxt    = '0;
          ev_down     = 1'b1;
        end
      end
    end else if (delay_r == '0 || TimeW'(now - att_time_r) >= delay_r) begin
      ev_connect   = 1'b1;
      att_time_nxt = now;
      if (in_item_r.connect_ok) begin
        link_up_nxt   = 1'b1;
        delay_nxt     = '0;
        chk_time_nxt  = now;
        sync_time_nxt = now;
        synced_nxt    = in_item_r.sync_status;
        addr_nxt      = in_item_r.address_in;
        ev_up         = 1'b1;
        ev_synced     = in_item_r.sync_status;
      end else begin
        synced_nxt = 1'b0;
        addr_nxt   = '0;
        delay_nxt  = grown_delay;
      end
    end

    // sync retry sees the state left by the link phase
    if (link_up_nxt && !synced_nxt &&
        TimeW'(now - sync_time_nxt) >= sync_interval_r) begin
      ev_sync       = 1'b1;
      sync_time_nxt = now;
      synced_nxt    = in_item_r.sync_status;
      if (in_item_r.sync_status) ev_synced = 1'b1;
    end

    ev_addr = (addr_nxt != addr_r);
  end

  always_comb begin
    out_item_nxt.connect_issued        = ev_connect;
    out_item_nxt.sync_issued           = ev_sync;
    out_item_nxt.connected_event       = ev_up;
    out_item_nxt.disconnected_event    = ev_down;
    out_item_nxt.synced_event          = ev_synced;
    out_item_nxt.address_changed_event = ev_addr;
    out_item_nxt.link_up_flag          = link_up_nxt;
    out_item_nxt.synced_flag           = synced_nxt;
    out_item_nxt.local_address         = addr_nxt;
    out_item_nxt.current_delay         = delay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r   <= 1'b0;
      synced_r    <= 1'b0;
      addr_r      <= '0;
      chk_time_r  <= '0;
      att_time_r  <= '0;
      delay_r     <= '0;
      sync_time_r <= '0;
    end else if (advance) begin
      link_up_r   <= link_up_nxt;
      synced_r    <= synced_nxt;
      addr_r      <= addr_nxt;
      chk_time_r  <= chk_time_nxt;
      att_time_r  <= att_time_nxt;
      delay_r     <= delay_nxt;
      sync_time_r <= sync_time_nxt;
    end
  end

  // while down the address is cleared, sync is dropped, and no delay is held while up
  `LKB_ASSERT_NOW(a_down_no_addr, clk, rst_n, !link_up_r, addr_r == '0, "address kept while down")
  `LKB_ASSERT_NOW(a_down_no_sync, clk, rst_n, !link_up_r, !synced_r, "synced while link down")
  `LKB_ASSERT_NOW(a_up_no_delay, clk, rst_n, link_up_r, delay_r == '0, "retry delay held while up")
  `LKB_ASSERT_NOW(a_up_needs_connect, clk, rst_n, out_valid_r && out_item_r.connected_event,
                  out_item_r.connect_issued, "connected without a connect attempt")
  `LKB_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance,
                   $stable(link_up_r) && $stable(delay_r), "state moved without a tick")

endmodule

FILE: tb/link_keeper_with_backoff_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_keeper_with_backoff_top_tb
// self-checking bench for the link keeper: ticks go in on the input stream,
// a predictor in the scoreboard works out each result, and every result
// transaction is compared field by field; config goes through the apb port
// between phases, with random idling on both streams
// ----------------------------------------------------------------------------
module link_keeper_with_backoff_top_tb;
  import lkb_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  // holds the predicted link keeper state and the results still to arrive
  class link_result_board;
    logic [31:0] status_iv, retry_init, retry_cap, sync_iv;
    logic        link_up, clock_synced;
    logic [31:0] stored_addr, last_check, last_attempt, retry_delay, last_sync;
    lkb_out_t    pending[$];
    int          errors;

    function void clear();
      status_iv    = StatusIntervalRst;
      retry_init   = RetryInitialRst;
      retry_cap    = RetryMaxRst;
      sync_iv      = SyncIntervalRst;
      link_up      = 1'b0;
      clock_synced = 1'b0;
      stored_addr  = '0;
      last_check   = '0;
      last_attempt = '0;
      retry_delay  = '0;
      last_sync    = '0;
      pending.delete();
      errors       = 0;
    endfunction

    function void set_reg(lkb_reg_t r, logic [31:0] v);
      case (r)
        REG_STATUS_INTERVAL: status_iv = v;
        REG_RETRY_INITIAL:   retry_init = v;
        REG_RETRY_MAX:       retry_cap = v;
        REG_SYNC_INTERVAL:   sync_iv = v;
        default: ;
      endcase
    endfunction

    // time at which the next action of the current state falls due
    function logic [31:0] due_time();
      if (!link_up) return last_attempt + retry_delay;
      if (!clock_synced && $urandom_range(0, 1) == 1) return last_sync + sync_iv;
      return last_check + status_iv;
    endfunction

    function logic [31:0] backoff(logic [31:0] d);
      if (d == '0) return retry_init;
      if (d < (retry_cap >> 1)) return d << 1;
      return retry_cap;
    endfunction

    function lkb_out_t predict_tick(lkb_in_t t);
      lkb_out_t    r;
      logic [31:0] elapsed;
      logic [31:0] new_addr;
      logic        touch_addr;
      r = '0;
      touch_addr = 1'b0;
      new_addr = '0;
      if (link_up) begin
        elapsed = t.now_ms - last_check;
        if (elapsed >= status_iv) begin
          last_check = t.now_ms;
          touch_addr = 1'b1;
          if (t.link_status) begin
            new_addr = t.address_in;
          end else begin
            link_up = 1'b0;
            clock_synced = 1'b0;
            retry_delay = '0;
            r.disconnected_event = 1'b1;
          end
        end
      end else begin
        elapsed = t.now_ms - last_attempt;
        if (retry_delay == '0 || elapsed >= retry_delay) begin
          r.connect_issued = 1'b1;
          last_attempt = t.now_ms;
          touch_addr = 1'b1;
          if (t.connect_ok) begin
            link_up = 1'b1;
            retry_delay = '0;
            last_check = t.now_ms;
            last_sync = t.now_ms;
            clock_synced = t.sync_status;
            new_addr = t.address_in;
            r.connected_event = 1'b1;
            r.synced_event = t.sync_status;
          end else begin
            clock_synced = 1'b0;
            retry_delay = backoff(retry_delay);
          end
        end
      end
      if (touch_addr && new_addr != stored_addr) begin
        stored_addr = new_addr;
        r.address_changed_event = 1'b1;
      end
      // sync retry is only looked at while linked and not yet synced
      elapsed = t.now_ms - last_sync;
      if (link_up && !clock_synced && elapsed >= sync_iv) begin
        r.sync_issued = 1'b1;
        last_sync = t.now_ms;
        clock_synced = t.sync_status;
        if (t.sync_status) r.synced_event = 1'b1;
      end
      r.link_up_flag  = link_up;
      r.synced_flag   = clock_synced;
      r.local_address = stored_addr;
      r.current_delay = retry_delay;
      return r;
    endfunction

    function void note_tick(lkb_in_t t);
      pending.push_back(predict_tick(t));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task cmp(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task cmp_bit(string what, logic got, logic want);
      if (got !== want) report(what, 32'(got), 32'(want));
    endtask

    task check_result(lkb_out_t got);
      lkb_out_t want;
      if (pending.size() == 0) begin
        report("result with nothing expected", got.current_delay, '0);
        return;
      end
      want = pending.pop_front();
      cmp_bit("connect_issued", got.connect_issued, want.connect_issued);
      cmp_bit("sync_issued", got.sync_issued, want.sync_issued);
      cmp_bit("connected_event", got.connected_event, want.connected_event);
      cmp_bit("disconnected_event", got.disconnected_event, want.disconnected_event);
      cmp_bit("synced_event", got.synced_event, want.synced_event);
      cmp_bit("address_changed_event", got.address_changed_event,
              want.address_changed_event);
      cmp_bit("link_up_flag", got.link_up_flag, want.link_up_flag);
      cmp_bit("synced_flag", got.synced_flag, want.synced_flag);
      cmp("local_address", got.local_address, want.local_address);
      cmp("current_delay", got.current_delay, want.current_delay);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  link_result_board sb;
  int unsigned      cycles;
  logic [31:0]      clock_ms;
  logic [31:0]      step_span;
  bit               calm_tx, calm_rx;
  int               stall_left;

  link_keeper_with_backoff_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    while (cycles < CycleLimit) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stall before each transaction
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      sb.check_result(out_tdata);
      stall_left = calm_rx ? 0 : $urandom_range(0, 13);
    end
  end

  task automatic send_tick(lkb_in_t t);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata = 72'({$urandom(), $urandom(), $urandom()});
      repeat (gap) @(negedge clk);
    end
    in_tdata = t;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t);
  endtask

  task automatic tick(logic [31:0] now, bit link, bit conn, bit sync, logic [31:0] addr);
    lkb_in_t t;
    t = '0;
    t.now_ms = now;
    t.link_status = link;
    t.connect_ok = conn;
    t.sync_status = sync;
    t.address_in = addr;
    clock_ms = now;
    send_tick(t);
  endtask

  function automatic lkb_in_t make_tick();
    lkb_in_t t;
    t = '0;
    case ($urandom_range(0, 11))
      0: ;
      1, 2, 3: clock_ms += $urandom_range(1, 8);
      4, 5: clock_ms += $urandom_range(0, step_span);
      6: clock_ms = $urandom();
      7: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4);
      // land on a deadline or one ms short of it
      default: clock_ms = sb.due_time() - $urandom_range(0, 1);
    endcase
    t.now_ms = clock_ms;
    if ($urandom_range(0, 4) == 0) begin
      t.link_status = 1'($urandom_range(0, 1));
      t.connect_ok = 1'($urandom_range(0, 1));
      t.sync_status = 1'($urandom_range(0, 1));
      t.address_in = $urandom();
    end else begin
      t.link_status = ($urandom_range(0, 9) != 0);
      t.connect_ok = 1'($urandom_range(0, 1));
      t.sync_status = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: t.address_in = '0;
        1: t.address_in = $urandom();
        default: t.address_in = sb.stored_addr;
      endcase
    end
    return t;
  endfunction

  // every result is in, so the block is idle
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(lkb_reg_t r, logic [31:0] v);
    logic [31:0] got;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {r, 2'b00};
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (got !== v) sb.report("register readback", got, v);
  endtask

  task automatic run_phase(logic [31:0] stat, logic [31:0] init, logic [31:0] cap,
                           logic [31:0] sync, int count, logic [31:0] span);
    settle();
    cfg_write(REG_STATUS_INTERVAL, stat);
    cfg_write(REG_RETRY_INITIAL, init);
    cfg_write(REG_RETRY_MAX, cap);
    cfg_write(REG_SYNC_INTERVAL, sync);
    step_span = span;
    calm_tx = ($urandom_range(0, 3) == 0);
    calm_rx = ($urandom_range(0, 3) == 0);
    repeat (count) send_tick(make_tick());
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    clock_ms = '0;
    step_span = 32'd20000;
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: failed connects, back-off, connect, checks, link loss
    tick(32'd0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
    tick(32'd999, 1'b0, 1'b1, 1'b1, 32'h0A00_0001);
    tick(32'd1000, 1'b0, 1'b0, 1'b0, 32'h0A00_0002);
    tick(32'd3000, 1'b0, 1'b1, 1'b1, 32'hC0A8_0001);
    tick(32'd7999, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
    tick(32'd8000, 1'b1, 1'b0, 1'b0, 32'hC0A8_0002);
    tick(32'd13000, 1'b1, 1'b1, 1'b1, 32'hC0A8_0002);
    tick(32'd18000, 1'b0, 1'b1, 1'b1, 32'h1234_5678);
    tick(32'd18000, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
    tick(32'd77999, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
    tick(32'd78000, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
    tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000);

    // zero intervals: loss, zero back-off, sync on the connect tick
    settle();
    cfg_write(REG_STATUS_INTERVAL, 32'd0);
    cfg_write(REG_RETRY_INITIAL, 32'd0);
    cfg_write(REG_RETRY_MAX, 32'd0);
    cfg_write(REG_SYNC_INTERVAL, 32'd0);
    tick(32'd5, 1'b0, 1'b1, 1'b1, 32'h5555_5555);
    tick(32'd5, 1'b0, 1'b0, 1'b1, 32'hAAAA_AAAA);
    tick(32'd6, 1'b1, 1'b1, 1'b0, 32'hAAAA_AAAA);
    tick(32'd6, 1'b1, 1'b0, 1'b1, 32'h5555_5555);
    tick(32'd7, 1'b0, 1'b0, 1'b0, 32'h0);
    tick(32'd8, 1'b0, 1'b1, 1'b1, 32'h8000_0001);

    // doubling up to the cap, both below and above half of it
    settle();
    cfg_write(REG_RETRY_INITIAL, 32'h4000_0000);
    cfg_write(REG_RETRY_MAX, 32'hFFFF_FFFF);
    tick(32'd9, 1'b1, 1'b1, 1'b1, 32'h8000_0001);
    tick(32'd10, 1'b0, 1'b1, 1'b1, 32'h1);
    tick(32'd10, 1'b0, 1'b0, 1'b0, 32'h1);
    tick(32'h4000_000A, 1'b0, 1'b0, 1'b0, 32'h2);
    tick(32'hC000_000A, 1'b0, 1'b0, 1'b0, 32'h3);

    run_phase(32'd3, 32'd1, 32'd16, 32'd2, 100, 32'd4);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 50, 32'd3);
    run_phase(32'hFFFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 50, 32'd1000);
    run_phase(32'd7, 32'd50, 32'd20, 32'd5, 60, 32'd40);
    run_phase(32'd5000, 32'd1000, 32'd60000, 32'd60000, 40, 32'd20000);
    run_phase($urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31),
              $urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31),
              40, 32'h0010_0000);
    run_phase(32'd2, 32'd3, 32'd101, 32'd1, 60, 32'd4);

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
